// ----- sv/pps_pkg.sv -----
`default_nettype none
package pps_pkg;

	// coordinate and score formats
	localparam int CW        = 16;
	localparam int CF        = 4;
	localparam int SF        = 10;
	localparam int SCW       = 16;
	localparam int NORM_BITS = 20;

	// working widths
	localparam int XW  = CW + 8;
	localparam int MW  = XW - 1;
	localparam int QBT = MW + SF;
	localparam int IW  = 2 * NORM_BITS + 5;
	localparam int KW  = $clog2(XW - NORM_BITS + 2);

	// divider depths; the IoU divider starts two stages later
	localparam int DEPTH_T = QBT;
	localparam int DEPTH_I = QBT - 2;

	typedef logic signed [XW-1:0] xw_t;

	localparam logic [1:0] ACT_FACE = 2'd0;
	localparam logic [1:0] ACT_HEAD = 2'd1;

	typedef enum logic [1:0] {
		ST_SCORED,
		ST_GATED,
		ST_UNSUP,
		ST_DEGEN
	} status_t;

	typedef struct packed {
		status_t status;
		logic    iou_zero;
		logic    ty_neg;
		logic    tx_neg;
	} side_t;

endpackage
`default_nettype wire

// ----- sv/pps_div.sv -----
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage, then pass stages.
// Computes floor((rem_in * 2^QB + num) / den) for rem_in < den.
module pps_div #(
	parameter int QB    = pps_pkg::QBT,
	parameter int DW    = pps_pkg::MW,
	parameter int DEPTH = pps_pkg::DEPTH_T
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [DW-1:0] rem_in,
	input  wire logic [QB-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic      [QB-1:0] quo,
	output logic               rem_nz
);

	logic [DW-1:0] rem_s [DEPTH];
	logic [DW-1:0] den_s [DEPTH];
	logic [QB-1:0] num_s [DEPTH];
	logic [QB-1:0] quo_s [DEPTH];

	for (genvar k = 0; k < DEPTH; k++) begin : g_stage
		logic [DW-1:0] rem_p;
		logic [DW-1:0] den_p;
		logic [QB-1:0] num_p;
		logic [QB-1:0] quo_p;
		logic [DW-1:0] rem_n;
		logic [QB-1:0] quo_n;

		if (k == 0) begin : g_first
			assign rem_p = rem_in;
			assign den_p = den;
			assign num_p = num;
			assign quo_p = '0;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign den_p = den_s[k-1];
			assign num_p = num_s[k-1];
			assign quo_p = quo_s[k-1];
		end

		if (k < QB) begin : g_step
			logic [DW:0] trial;
			assign trial = {rem_p, num_p[QB-1]};
			always_comb begin
				if (trial >= {1'b0, den_p}) begin
					rem_n = DW'(trial - {1'b0, den_p});
					quo_n = {quo_p[QB-2:0], 1'b1};
				end else begin
					rem_n = trial[DW-1:0];
					quo_n = {quo_p[QB-2:0], 1'b0};
				end
			end
		end else begin : g_pass
			assign rem_n = rem_p;
			assign quo_n = quo_p;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rem_n;
				den_s[k] <= den_p;
				num_s[k] <= {num_p[QB-2:0], 1'b0};
				quo_s[k] <= quo_n;
			end
		end
	end

	assign quo    = quo_s[DEPTH-1];
	assign rem_nz = |rem_s[DEPTH-1];

endmodule
`default_nettype wire

// ----- sv/part_to_person_pair_score_core.sv -----
`default_nettype none
// Channel  Dir  tdata (low bit up)                         tuser
// s_       in   a_left a_top a_right a_bottom               action [1:0]
//               b_left b_top b_right b_bottom (16b each)
// m_       out  score [15:0]                                status [1:0]
//
// One transaction per cycle in and out unless the output stalls. Four front stages
// feed the vertical and horizontal term dividers of QBT = 33 stages (one quotient
// bit per stage), then one output stage. The IoU divider starts after stage 6 and
// runs 31 stages (10 quotient bits, then pass stages) so all three terms line up.
// arst_n clears all valid bits; payload registers carry no reset.
// A stalled output holds the whole pipeline; s_tready follows m_tready
// whenever a result is waiting, nothing is dropped or repeated.
module part_to_person_pair_score_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [127:0] s_tdata,  // a_left a_top a_right a_bottom b_left b_top b_right b_bottom
	input  wire logic [1:0]   s_tuser,  // action
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [15:0]       m_tdata,  // score
	output logic [1:0]        m_tuser   // status
);

	localparam int CW  = pps_pkg::CW;
	localparam int CF  = pps_pkg::CF;
	localparam int SF  = pps_pkg::SF;
	localparam int XW  = pps_pkg::XW;
	localparam int MW  = pps_pkg::MW;
	localparam int NB  = pps_pkg::NORM_BITS;
	localparam int KW  = pps_pkg::KW;
	localparam int IW  = pps_pkg::IW;
	localparam int QBT = pps_pkg::QBT;
	localparam int DI  = pps_pkg::DEPTH_I;
	localparam int SCW = pps_pkg::SCW;
	localparam int PW  = 2 * NB;
	localparam int SW  = QBT + 3;

	localparam pps_pkg::xw_t ONE_PX = pps_pkg::xw_t'(1 << CF);
	localparam pps_pkg::xw_t RND2F  = pps_pkg::xw_t'((1 << (CF + 1)) - 1);
	localparam pps_pkg::xw_t C2  = 2;
	localparam pps_pkg::xw_t C4  = 4;
	localparam pps_pkg::xw_t C5  = 5;
	localparam pps_pkg::xw_t C7  = 7;
	localparam pps_pkg::xw_t C10 = 10;
	localparam pps_pkg::xw_t C15 = 15;
	localparam pps_pkg::xw_t C18 = 18;
	localparam pps_pkg::xw_t C20 = 20;
	localparam pps_pkg::xw_t C50 = 50;
	localparam logic signed [SW-1:0] SAT_HI = SW'((1 << (SCW - 1)) - 1);
	localparam logic signed [SW-1:0] SAT_LO = -SW'(1 << (SCW - 1));

	function automatic pps_pkg::xw_t sext(input logic [CW-1:0] v);
		return pps_pkg::xw_t'(signed'(v));
	endfunction

	function automatic pps_pkg::xw_t smax(input pps_pkg::xw_t a, input pps_pkg::xw_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic pps_pkg::xw_t smin(input pps_pkg::xw_t a, input pps_pkg::xw_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pps_pkg::xw_t sabs(input pps_pkg::xw_t a);
		return (a < 0) ? -a : a;
	endfunction

	// divide by 2F, truncating toward zero
	function automatic pps_pkg::xw_t tdiv2f(input pps_pkg::xw_t v);
		pps_pkg::xw_t b;
		b = (v < 0) ? v + RND2F : v;
		return b >>> (CF + 1);
	endfunction

	// right shift that brings a side length down to NB bits
	function automatic logic [KW-1:0] nshift(input pps_pkg::xw_t m);
		logic [KW-1:0] k;
		k = '0;
		for (int i = NB; i < XW; i++) begin
			if (m[i]) begin
				k = KW'(i + 1 - NB);
			end
		end
		return k;
	endfunction

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ---------------- stage 1: differences, sums, early status
	pps_pkg::xw_t in_al, in_at, in_ar, in_ab, in_bl, in_bt, in_br, in_bb;
	pps_pkg::xw_t in_aw, in_ah, in_pw, in_ph, in_size;

	assign in_al   = sext(s_tdata[0*CW +: CW]);
	assign in_at   = sext(s_tdata[1*CW +: CW]);
	assign in_ar   = sext(s_tdata[2*CW +: CW]);
	assign in_ab   = sext(s_tdata[3*CW +: CW]);
	assign in_bl   = sext(s_tdata[4*CW +: CW]);
	assign in_bt   = sext(s_tdata[5*CW +: CW]);
	assign in_br   = sext(s_tdata[6*CW +: CW]);
	assign in_bb   = sext(s_tdata[7*CW +: CW]);
	assign in_aw   = in_ar - in_al;
	assign in_ah   = in_ab - in_at;
	assign in_pw   = in_br - in_bl;
	assign in_ph   = in_bb - in_bt;
	assign in_size = smax(in_aw, in_ah);

	logic         v_s1, head_s1, unsup_s1, degen_s1;
	pps_pkg::xw_t al_s1, at_s1, ar_s1, ab_s1, bl_s1, bt_s1, br_s1;
	pps_pkg::xw_t ah_s1, pw_s1, ph_s1, sax_s1, say_s1, sbx_s1, sby_s1, size_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			head_s1  <= (s_tuser == pps_pkg::ACT_HEAD);
			unsup_s1 <= (s_tuser != pps_pkg::ACT_FACE) && (s_tuser != pps_pkg::ACT_HEAD);
			degen_s1 <= (in_aw <= 0) || (in_ah <= 0) || (in_pw <= 0) || (in_ph <= 0) ||
				(in_size < ONE_PX);
			al_s1   <= in_al;
			at_s1   <= in_at;
			ar_s1   <= in_ar;
			ab_s1   <= in_ab;
			bl_s1   <= in_bl;
			bt_s1   <= in_bt;
			br_s1   <= in_br;
			ah_s1   <= in_ah;
			pw_s1   <= in_pw;
			ph_s1   <= in_ph;
			sax_s1  <= in_al + in_ar;
			say_s1  <= in_at + in_ab;
			sbx_s1  <= in_bl + in_br;
			sby_s1  <= in_bt + in_bb;
			size_s1 <= in_size;
		end
	end

	// ---------------- stage 2: part size, centers, scaled boxes for IoU
	pps_pkg::xw_t c2_sz, c2_spx;
	pps_pkg::xw_t c2_pa [4];
	pps_pkg::xw_t c2_tb [4];

	assign c2_sz  = size_s1 & ~(ONE_PX - pps_pkg::xw_t'(1));
	assign c2_spx = size_s1 >>> CF;

	always_comb begin
		c2_pa[0] = al_s1 * C5;
		c2_pa[2] = ar_s1 * C5;
		c2_tb[0] = bl_s1 * C5 + pw_s1;
		if (head_s1) begin
			// x and y scaled by 5
			c2_pa[1] = at_s1 * C5;
			c2_pa[3] = ab_s1 * C5;
			c2_tb[1] = bt_s1 * C5 + c2_sz;
			c2_tb[2] = br_s1 * C5;
			c2_tb[3] = bt_s1 * C5 + c2_sz * C7;
		end else begin
			// x scaled by 5, y scaled by 4
			c2_pa[1] = at_s1 * C4;
			c2_pa[3] = ab_s1 * C4;
			c2_tb[1] = bt_s1 * C4 + c2_sz;
			c2_tb[2] = bl_s1 * C5 + pw_s1 * C4;
			c2_tb[3] = at_s1 * C4 + c2_sz * C5;
		end
	end

	logic         v_s2, head_s2, unsup_s2, degen_s2;
	pps_pkg::xw_t pa_s2 [4];
	pps_pkg::xw_t tb_s2 [4];
	pps_pkg::xw_t sz_s2, spx_s2, pc_s2, fcx_s2, ah_s2, ph_s2, sax_s2, say_s2, sby_s2;
	pps_pkg::xw_t at_s2, bt_s2, bl_s2, br_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			head_s2  <= head_s1;
			unsup_s2 <= unsup_s1;
			degen_s2 <= degen_s1;
			pa_s2    <= c2_pa;
			tb_s2    <= c2_tb;
			sz_s2    <= c2_sz;
			spx_s2   <= c2_spx;
			pc_s2    <= tdiv2f(sbx_s1);
			fcx_s2   <= tdiv2f(sax_s1);
			ah_s2    <= ah_s1;
			ph_s2    <= ph_s1;
			sax_s2   <= sax_s1;
			say_s2   <= say_s1;
			sby_s2   <= sby_s1;
			at_s2    <= at_s1;
			bt_s2    <= bt_s1;
			bl_s2    <= bl_s1;
			br_s2    <= br_s1;
		end
	end

	// ---------------- stage 3: gates, overlap sides, term fractions
	logic         c3_gate;
	pps_pkg::xw_t c3_nty, c3_dty, c3_ntx, c3_dtx;

	always_comb begin
		if (head_s2) begin
			c3_gate = (sax_s2 <= bl_s2 * C2) || (sax_s2 >= br_s2 * C2) ||
				(say_s2 >= sby_s2) || (ph_s2 > sz_s2 * C15);
			c3_nty  = ah_s2 - sabs(at_s2 - bt_s2);
			c3_dty  = ah_s2 * C5;
			c3_ntx  = sz_s2 * C2 - sabs((pc_s2 <<< (CF + 1)) - sax_s2);
			c3_dtx  = sz_s2 * C20;
		end else begin
			c3_gate = (say_s2 < bt_s2 * C2) || (ph_s2 > sz_s2 * C18);
			c3_nty  = ah_s2 * C10 - (say_s2 * C5 - bt_s2 * C10 - sz_s2 * C7);
			c3_dty  = ah_s2 * C50;
			c3_ntx  = spx_s2 - sabs(pc_s2 - fcx_s2);
			c3_dtx  = spx_s2 * C10;
		end
	end

	logic         v_s3, head_s3, unsup_s3, degen_s3, gate_s3;
	pps_pkg::xw_t iw_s3, ih_s3, saw_s3, sah_s3, stw_s3, sth_s3;
	pps_pkg::xw_t nty_s3, dty_s3, ntx_s3, dtx_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			head_s3  <= head_s2;
			unsup_s3 <= unsup_s2;
			degen_s3 <= degen_s2;
			gate_s3  <= c3_gate;
			iw_s3    <= smin(pa_s2[2], tb_s2[2]) - smax(pa_s2[0], tb_s2[0]);
			ih_s3    <= smin(pa_s2[3], tb_s2[3]) - smax(pa_s2[1], tb_s2[1]);
			saw_s3   <= pa_s2[2] - pa_s2[0];
			sah_s3   <= pa_s2[3] - pa_s2[1];
			stw_s3   <= tb_s2[2] - tb_s2[0];
			sth_s3   <= tb_s2[3] - tb_s2[1];
			nty_s3   <= c3_nty;
			dty_s3   <= c3_dty;
			ntx_s3   <= c3_ntx;
			dtx_s3   <= c3_dtx;
		end
	end

	// ---------------- stage 4: overlap test, normalizing shifts, magnitudes
	pps_pkg::xw_t c4_tya, c4_txa;
	assign c4_tya = sabs(nty_s3);
	assign c4_txa = sabs(ntx_s3);

	logic          v_s4, head_s4, unsup_s4, degen_s4, gate_s4, ov_s4, tyn_s4, txn_s4;
	logic [KW-1:0] kx_s4, ky_s4;
	pps_pkg::xw_t  iw_s4, ih_s4, saw_s4, sah_s4, stw_s4, sth_s4;
	logic [MW-1:0] tym_s4, dty_s4, txm_s4, dtx_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			head_s4  <= head_s3;
			unsup_s4 <= unsup_s3;
			degen_s4 <= degen_s3;
			gate_s4  <= gate_s3;
			ov_s4    <= (iw_s3 > 0) && (ih_s3 > 0);
			kx_s4    <= nshift(smax(saw_s3, stw_s3));
			ky_s4    <= nshift(smax(sah_s3, sth_s3));
			iw_s4    <= iw_s3;
			ih_s4    <= ih_s3;
			saw_s4   <= saw_s3;
			sah_s4   <= sah_s3;
			stw_s4   <= stw_s3;
			sth_s4   <= sth_s3;
			tyn_s4   <= (nty_s3 < 0);
			txn_s4   <= (ntx_s3 < 0);
			tym_s4   <= c4_tya[MW-1:0];
			txm_s4   <= c4_txa[MW-1:0];
			dty_s4   <= dty_s3[MW-1:0];
			dtx_s4   <= dtx_s3[MW-1:0];
		end
	end

	// vertical and horizontal terms: floor(|n| * 2^SF / d)
	logic [QBT-1:0] ty_quo, tx_quo;
	logic           ty_rnz, tx_rnz;

	pps_div #(
		.QB    (QBT),
		.DW    (MW),
		.DEPTH (pps_pkg::DEPTH_T)
	) u_div_ty (
		.clk    (clk),
		.en     (en),
		.rem_in ('0),
		.num    ({tym_s4, {SF{1'b0}}}),
		.den    (dty_s4),
		.quo    (ty_quo),
		.rem_nz (ty_rnz)
	);

	pps_div #(
		.QB    (QBT),
		.DW    (MW),
		.DEPTH (pps_pkg::DEPTH_T)
	) u_div_tx (
		.clk    (clk),
		.en     (en),
		.rem_in ('0),
		.num    ({txm_s4, {SF{1'b0}}}),
		.den    (dtx_s4),
		.quo    (tx_quo),
		.rem_nz (tx_rnz)
	);

	// ---------------- stage 5: normalized areas
	logic [XW-1:0] c5_iw, c5_ih, c5_saw, c5_sah, c5_stw, c5_sth;
	assign c5_iw  = $unsigned(iw_s4) >> kx_s4;
	assign c5_ih  = $unsigned(ih_s4) >> ky_s4;
	assign c5_saw = $unsigned(saw_s4) >> kx_s4;
	assign c5_sah = $unsigned(sah_s4) >> ky_s4;
	assign c5_stw = $unsigned(stw_s4) >> kx_s4;
	assign c5_sth = $unsigned(sth_s4) >> ky_s4;

	logic          v_s5, head_s5, unsup_s5, degen_s5, gate_s5, ov_s5, tyn_s5, txn_s5;
	logic [PW-1:0] inter_s5, area_a_s5, area_t_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			head_s5   <= head_s4;
			unsup_s5  <= unsup_s4;
			degen_s5  <= degen_s4;
			gate_s5   <= gate_s4;
			ov_s5     <= ov_s4;
			tyn_s5    <= tyn_s4;
			txn_s5    <= txn_s4;
			inter_s5  <= c5_iw[NB-1:0] * c5_ih[NB-1:0];
			area_a_s5 <= c5_saw[NB-1:0] * c5_sah[NB-1:0];
			area_t_s5 <= c5_stw[NB-1:0] * c5_sth[NB-1:0];
		end
	end

	// ---------------- stage 6: union, head overlap gate, final status
	logic [PW:0]     c6_uni;
	logic            c6_hgate, c6_izero;
	pps_pkg::status_t c6_status;

	assign c6_uni   = {1'b0, area_a_s5} + {1'b0, area_t_s5} - {1'b0, inter_s5};
	assign c6_izero = !ov_s5 || (inter_s5 == '0);
	assign c6_hgate = head_s5 &&
		(!ov_s5 || ({3'b000, inter_s5} * 5 < {3'b000, area_a_s5} * 4));

	always_comb begin
		if (unsup_s5) begin
			c6_status = pps_pkg::ST_UNSUP;
		end else if (degen_s5) begin
			c6_status = pps_pkg::ST_DEGEN;
		end else if (gate_s5 || c6_hgate) begin
			c6_status = pps_pkg::ST_GATED;
		end else begin
			c6_status = pps_pkg::ST_SCORED;
		end
	end

	logic           v_s6;
	logic [IW-1:0]  ri_s6, di_s6;
	pps_pkg::side_t side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ri_s6            <= c6_izero ? '0 : IW'({3'b000, inter_s5} * 7);
			di_s6            <= IW'({4'b0000, c6_uni} * 10);
			side_s6.status   <= c6_status;
			side_s6.iou_zero <= c6_izero;
			side_s6.ty_neg   <= tyn_s5;
			side_s6.tx_neg   <= txn_s5;
		end
	end

	// IoU term: floor(7 * inter * 2^SF / (10 * union)), quotient below 2^SF
	logic [SF-1:0] ti_quo;
	logic          ti_rnz;

	pps_div #(
		.QB    (SF),
		.DW    (IW),
		.DEPTH (DI)
	) u_div_iou (
		.clk    (clk),
		.en     (en),
		.rem_in (ri_s6),
		.num    ('0),
		.den    (di_s6),
		.quo    (ti_quo),
		.rem_nz (ti_rnz)
	);

	// carry status and signs alongside the dividers
	logic           v_dl    [DI];
	pps_pkg::side_t side_dl [DI];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DI; i++) begin
				v_dl[i] <= 1'b0;
			end
		end else if (en) begin
			v_dl[0] <= v_s6;
			for (int i = 1; i < DI; i++) begin
				v_dl[i] <= v_dl[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_dl[0] <= side_s6;
			for (int i = 1; i < DI; i++) begin
				side_dl[i] <= side_dl[i-1];
			end
		end
	end

	// ---------------- output stage: floor fix, sum, saturate
	pps_pkg::side_t        fin_side;
	logic signed [SW-1:0]  fin_ty, fin_tx, fin_ti, fin_sum;
	logic signed [SW-1:0]  ty_mag, tx_mag;
	logic [SCW-1:0]        fin_score;

	assign fin_side = side_dl[DI-1];
	assign ty_mag   = $signed({3'b000, ty_quo});
	assign tx_mag   = $signed({3'b000, tx_quo});
	assign fin_ty   = fin_side.ty_neg ? -(ty_mag + SW'(ty_rnz)) : ty_mag;
	assign fin_tx   = fin_side.tx_neg ? -(tx_mag + SW'(tx_rnz)) : tx_mag;
	assign fin_ti   = fin_side.iou_zero ? '0 : $signed({{(SW - SF){1'b0}}, ti_quo});
	assign fin_sum  = fin_ty + fin_tx + fin_ti;

	always_comb begin
		if (fin_side.status != pps_pkg::ST_SCORED) begin
			fin_score = '0;
		end else if (fin_sum > SAT_HI) begin
			fin_score = SAT_HI[SCW-1:0];
		end else if (fin_sum < SAT_LO) begin
			fin_score = SAT_LO[SCW-1:0];
		end else begin
			fin_score = fin_sum[SCW-1:0];
		end
	end

	logic [SCW-1:0] score_q;
	logic [1:0]     status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= v_dl[DI-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			score_q  <= fin_score;
			status_q <= fin_side.status;
		end
	end

	assign m_tdata = score_q;
	assign m_tuser = status_q;

	logic unused_ti_rnz;
	assign unused_ti_rnz = ti_rnz;

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// one box pair as it travels on the slave side
	typedef struct {
		logic [1:0]         action;
		logic signed [15:0] al, at, ar, ab, bl, bt, br, bb;
	} pair_t;

	// one scored result as it travels on the master side
	typedef struct {
		logic [15:0] score;
		logic [1:0]  status;
	} score_t;

	localparam int PIPE_LAT    = 38;
	localparam int CYCLE_LIMIT = 400000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [15:0]  m_tdata;
	logic [1:0]   m_tuser;

	pair_t  pending_pairs[$];
	score_t expected_scores[$];
	int     error_count;
	int     cycle_count = 0;
	bit     stim_done;
	int     burst_left;
	int     gap_left;
	int     stall_phase;
	int     stall_period;

	part_to_person_pair_score_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),  // a_left a_top a_right a_bottom b_left b_top b_right b_bottom
		.s_tuser  (s_tuser),  // action
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),  // score
		.m_tuser  (m_tuser)   // status
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Floor division on exact integers.
	function automatic longint floor_quot(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && ((n < 0) != (d < 0)))
			q = q - 1;
		return q;
	endfunction

	function automatic longint abs_l(longint a);
		return (a < 0) ? -a : a;
	endfunction

	function automatic longint max_l(longint a, longint b);
		return (a > b) ? a : b;
	endfunction

	function automatic longint min_l(longint a, longint b);
		return (a < b) ? a : b;
	endfunction

	// Shift that brings a side length down to NORM_BITS bits.
	function automatic int side_shift(longint m);
		int b;
		b = 0;
		while (m != 0) begin
			b++;
			m = m >>> 1;
		end
		return (b > pps_pkg::NORM_BITS) ? b - pps_pkg::NORM_BITS : 0;
	endfunction

	// Normalized intersection and areas of the part box and the derived box;
	// returns 0 when the boxes do not overlap.
	function automatic bit box_overlap(input longint p[4], input longint d[4],
			output longint inter, output longint area_p, output longint area_d);
		longint iw, ih, pw, ph, dw, dh;
		int kx, ky;
		iw = min_l(p[2], d[2]) - max_l(p[0], d[0]);
		ih = min_l(p[3], d[3]) - max_l(p[1], d[1]);
		inter = 0;
		area_p = 0;
		area_d = 0;
		if (iw <= 0 || ih <= 0)
			return 1'b0;
		pw = p[2] - p[0];
		ph = p[3] - p[1];
		dw = d[2] - d[0];
		dh = d[3] - d[1];
		kx = side_shift(max_l(pw, dw));
		ky = side_shift(max_l(ph, dh));
		inter  = (iw >>> kx) * (ih >>> ky);
		area_p = (pw >>> kx) * (ph >>> ky);
		area_d = (dw >>> kx) * (dh >>> ky);
		return 1'b1;
	endfunction

	// Association score of one part/person pair.
	function automatic score_t assoc_score_of(pair_t x);
		score_t r;
		longint fx, one, ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
		longint aw, ah, pw, ph, size_px, sz, pc, ty, tx, ti, total;
		longint yd10, fcx, xd2, inter, area_p, area_d;
		longint pa[4], tbx[4];
		bit ov;
		fx  = 64'sd1 << pps_pkg::CF;
		one = 64'sd1 << pps_pkg::SF;
		ax1 = x.al; ay1 = x.at; ax2 = x.ar; ay2 = x.ab;
		bx1 = x.bl; by1 = x.bt; bx2 = x.br; by2 = x.bb;
		aw = ax2 - ax1; ah = ay2 - ay1; pw = bx2 - bx1; ph = by2 - by1;
		r.score = '0;
		if (x.action != pps_pkg::ACT_FACE && x.action != pps_pkg::ACT_HEAD) begin
			r.status = pps_pkg::ST_UNSUP;
			return r;
		end
		if (aw <= 0 || ah <= 0 || pw <= 0 || ph <= 0 || max_l(aw, ah) < fx) begin
			r.status = pps_pkg::ST_DEGEN;
			return r;
		end
		size_px = max_l(aw, ah) / fx;
		sz = size_px * fx;
		pc = (bx1 + bx2) / (2 * fx);  // truncates toward zero
		if (x.action == pps_pkg::ACT_FACE) begin
			if (ay1 + ay2 < 2 * by1 || ph > 18 * sz) begin
				r.status = pps_pkg::ST_GATED;
				return r;
			end
			yd10 = 5 * (ay1 + ay2) - 10 * by1 - 7 * sz;
			ty = floor_quot((10 * ah - yd10) * one, 50 * ah);
			fcx = (ax1 + ax2) / (2 * fx);
			tx = floor_quot((size_px - abs_l(pc - fcx)) * one, 10 * size_px);
			// x scaled by 5, y by 4 keeps the upper-body box exact
			pa[0] = 5 * ax1; pa[1] = 4 * ay1; pa[2] = 5 * ax2; pa[3] = 4 * ay2;
			tbx[0] = 5 * bx1 + pw; tbx[1] = 4 * by1 + sz;
			tbx[2] = 5 * bx1 + 4 * pw; tbx[3] = 4 * ay1 + 5 * sz;
			ov = box_overlap(pa, tbx, inter, area_p, area_d);
		end else begin
			if (ax1 + ax2 <= 2 * bx1 || ax1 + ax2 >= 2 * bx2 ||
					ay1 + ay2 >= by1 + by2 || ph > 15 * sz) begin
				r.status = pps_pkg::ST_GATED;
				return r;
			end
			pa[0] = 5 * ax1; pa[1] = 5 * ay1; pa[2] = 5 * ax2; pa[3] = 5 * ay2;
			tbx[0] = 5 * bx1 + pw; tbx[1] = 5 * by1 + sz;
			tbx[2] = 5 * bx2; tbx[3] = 5 * by1 + 7 * sz;
			ov = box_overlap(pa, tbx, inter, area_p, area_d);
			// head must sit mostly inside the derived box
			if (!ov || 5 * inter < 4 * area_p) begin
				r.status = pps_pkg::ST_GATED;
				return r;
			end
			ty = floor_quot((ah - abs_l(ay1 - by1)) * one, 5 * ah);
			xd2 = abs_l(2 * fx * pc - (ax1 + ax2));
			tx = floor_quot((2 * sz - xd2) * one, 20 * sz);
		end
		if (!ov || inter == 0)
			ti = 0;
		else
			ti = ((7 * inter) << pps_pkg::SF) / (10 * (area_p + area_d - inter));
		total = ty + ti + tx;
		if (total > 32767)
			total = 32767;
		if (total < -32768)
			total = -32768;
		r.score  = total[15:0];
		r.status = pps_pkg::ST_SCORED;
		return r;
	endfunction

	function automatic logic signed [15:0] rnd_coord();
		return 16'($urandom);
	endfunction

	// Queue one pair and its expected score.
	task automatic push_pair(pair_t x);
		pending_pairs.push_back(x);
		expected_scores.push_back(assoc_score_of(x));
	endtask

	// Plausible face or head with a person box around it; mostly scored.
	task automatic push_plausible(logic [1:0] act, int scale);
		pair_t x;
		int cx, cy, sz, pw, ph;
		sz = $urandom_range(16, 16 * scale);
		cx = $signed($urandom_range(0, 40000)) - 20000;
		cy = $signed($urandom_range(0, 40000)) - 20000;
		pw = sz * $urandom_range(15, 50) / 10 + $urandom_range(0, 30);
		ph = sz * $urandom_range(20, 170) / 10 + $urandom_range(0, 30);
		x.action = act;
		x.al = 16'(cx - sz / 2 + $signed($urandom_range(0, 6)) - 3);
		x.ar = 16'(cx + sz / 2 + $signed($urandom_range(0, 6)) - 3);
		x.at = 16'(cy - sz / 2);
		x.ab = 16'(cy + sz / 2 + $signed($urandom_range(0, 4)) - 2);
		x.bl = 16'(cx - pw / 2 + $signed($urandom_range(0, 2 * sz)) - sz);
		x.br = 16'(x.bl + pw);
		x.bt = 16'(cy - sz * $urandom_range(0, 20) / 10 - $urandom_range(0, 8));
		x.bb = 16'(x.bt + ph);
		push_pair(x);
	endtask

	task automatic push_noise();
		pair_t x;
		x.action = 2'($urandom_range(0, 3));
		x.al = rnd_coord(); x.at = rnd_coord(); x.ar = rnd_coord(); x.ab = rnd_coord();
		x.bl = rnd_coord(); x.bt = rnd_coord(); x.br = rnd_coord(); x.bb = rnd_coord();
		push_pair(x);
	endtask

	task automatic push_box(logic [1:0] act, int al, int at, int ar, int ab,
			int bl, int bt, int br, int bb);
		pair_t x;
		x.action = act;
		x.al = 16'(al); x.at = 16'(at); x.ar = 16'(ar); x.ab = 16'(ab);
		x.bl = 16'(bl); x.bt = 16'(bt); x.br = 16'(br); x.bb = 16'(bb);
		push_pair(x);
	endtask

	task automatic report_mismatch(string what, score_t got, score_t want);
		$display("mismatch %s: score %0d status %0d, expected score %0d status %0d",
			what, $signed(got.score), got.status, $signed(want.score), want.status);
		error_count++;
	endtask

	// Stimulus: directed corners first, then mostly plausible pairs.
	initial begin
		int pick;
		error_count = 0;
		stim_done = 1'b0;
		// unsupported kinds
		push_box(2'd2, 0, 0, 160, 160, -100, -50, 300, 2000);
		push_box(2'd3, 0, 0, 160, 160, -100, -50, 300, 2000);
		// degenerate: zero width part, negative height person, sub-pixel part
		push_box(pps_pkg::ACT_FACE, 10, 0, 10, 160, -100, -50, 300, 2000);
		push_box(pps_pkg::ACT_HEAD, 0, 0, 160, 160, -100, 500, 300, 400);
		push_box(pps_pkg::ACT_FACE, 0, 0, 15, 15, -100, -50, 300, 2000);
		push_box(pps_pkg::ACT_HEAD, 0, 0, 16, 16, 0, 0, 1, 1);
		// face: plain scored, above person top, tall person, extremes
		push_box(pps_pkg::ACT_FACE, 0, 0, 160, 160, -160, -40, 320, 1600);
		push_box(pps_pkg::ACT_FACE, 0, -400, 160, -240, -160, -40, 320, 1600);
		push_box(pps_pkg::ACT_FACE, 0, 0, 160, 160, -160, -40, 320, 3000);
		push_box(pps_pkg::ACT_FACE, -32768, -32768, 32767, 32767,
			-32768, -32768, 32767, 32767);
		push_box(pps_pkg::ACT_FACE, 16000, 0, 16016, 16, -32768, -8, -32700, 200);
		push_box(pps_pkg::ACT_FACE, 0, 0, 160, 160, 5000, -40, 5400, 1600);
		// head: scored, centre at left, below centre, tall, no overlap, small overlap
		push_box(pps_pkg::ACT_HEAD, 0, 0, 160, 160, -160, -20, 320, 1800);
		push_box(pps_pkg::ACT_HEAD, -160, 0, 160, 160, 0, -20, 320, 1800);
		push_box(pps_pkg::ACT_HEAD, 0, 1500, 160, 1660, -160, -20, 320, 1800);
		push_box(pps_pkg::ACT_HEAD, 0, 0, 160, 160, -160, -20, 320, 3000);
		push_box(pps_pkg::ACT_HEAD, 0, 0, 160, 160, 40, 150, 120, 1800);
		push_box(pps_pkg::ACT_HEAD, 0, 0, 160, 160, 100, -20, 180, 1800);
		push_box(pps_pkg::ACT_HEAD, -32768, -32768, 32767, 32767,
			-32768, -32768, 32767, 32767);
		push_box(pps_pkg::ACT_HEAD, -32768, -32768, -32752, -32752,
			-32768, -32768, 32767, 32767);
		for (int i = 0; i < 1350; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				push_plausible(pps_pkg::ACT_FACE, (pick < 4) ? 2000 : 20);
			else if (pick < 80)
				push_plausible(pps_pkg::ACT_HEAD, (pick < 44) ? 2000 : 20);
			else
				push_noise();
		end
		stim_done = 1'b1;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: bursts of transactions separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		pair_t x;
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else if (!s_tvalid || s_tready) begin
			// the current transaction (if any) was taken; pick the next
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (pending_pairs.size() == 0) begin
				s_tvalid <= 1'b0;
			end else begin
				x = pending_pairs.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= x.action;
				s_tdata  <= {x.bb, x.br, x.bt, x.bl, x.ab, x.ar, x.at, x.al};
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Receiver stall pattern: a random period with one stall window, reshuffled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready     <= 1'b0;
			stall_phase  <= 0;
			stall_period <= 8;
		end else begin
			if (stall_phase + 1 >= stall_period) begin
				stall_phase  <= 0;
				stall_period <= $urandom_range(2, 60);
			end else begin
				stall_phase <= stall_phase + 1;
			end
			// long periods leave stretches with no stall at all
			m_tready <= (stall_period > 45) || (stall_phase >= stall_period / 3);
		end
	end

	// Monitor: compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		score_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.score  = m_tdata;
			got.status = m_tuser;
			if (expected_scores.size() == 0) begin
				want.score  = '0;
				want.status = '0;
				report_mismatch("unexpected result", got, want);
			end else begin
				want = expected_scores.pop_front();
				if (got.status !== want.status)
					report_mismatch("status", got, want);
				else if (got.score !== want.score)
					report_mismatch("score", got, want);
			end
		end
	end

	// Run limit and end of test.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		while (pending_pairs.size() != 0 || expected_scores.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
		if (error_count == 0 && expected_scores.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
